FILE: rtl/bqf_pkg.sv
`timescale 1ns / 1ps
package bqf_pkg;

  // Default widths of the sample and coefficient words.
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 32;

  // Configuration register file.
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_FEED_ZERO = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FEED_ONE  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FEED_TWO  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BACK_ONE  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BACK_TWO  = 3'd4;

  // Datapath operations, one per sequencer step after the first product.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
  localparam logic [OP_W-1:0] OP_OUTPUT = 3'd1;  // form and saturate y, start b1*x
  localparam logic [OP_W-1:0] OP_S1_FF  = 3'd2;  // s1 = b1*x + s2, start b2*x
  localparam logic [OP_W-1:0] OP_S2_FF  = 3'd3;  // s2 = b2*x, start a1*y
  localparam logic [OP_W-1:0] OP_S1_FB  = 3'd4;  // s1 -= a1*y, start a2*y
  localparam logic [OP_W-1:0] OP_COMMIT = 3'd5;  // s2 -= a2*y, update states, load output

  typedef struct packed {
    logic            accept;  // capture the sample and start b0*x
    logic [OP_W-1:0] op;
  } bqf_cmd_t;

endpackage

FILE: rtl/biquad_filter_core.sv
`timescale 1ns / 1ps
// A result is valid after the output, S1_FF, S2_FF, S1_FB and commit steps;
// a new sample is taken only while idle. The single shared multiplier forms
// the five products b0*x, b1*x, b2*x, a1*y and a2*y one after another.
// Reset (rst, synchronous, active high) clears both delay states, loads b0 with
// 1.0 and the other coefficients with zero, and empties the output register.
module biquad_filter_core #(
  parameter int SAMPLE_WIDTH = bqf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = bqf_pkg::COEF_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port; indexes above the last coefficient are ignored.
  input  logic                             cfg_write_en,
  input  logic [bqf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic signed [COEF_WIDTH-1:0]     cfg_data,
  // Input sample channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_in,
  input  logic                             end_of_block,
  // Output sample channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]   sample_out,
  output logic                             end_of_block_out,
  output logic                             clipped
);

  // The controller steps through the product sequence and tells the datapath
  // which operation to perform each cycle. An input transaction is taken only
  // while the sequencer is idle; the finished sample sits in an output
  // register, so a new input transaction can begin while the previous output
  // transaction is still stalled. The last step waits while that output stalls.
  bqf_pkg::bqf_cmd_t cmd;

  bqf_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The datapath holds the coefficients, the two 40-bit delay states, the
  // shared multiplier with its product register and the two accumulators.
  // Products are truncated by an arithmetic shift of the coefficient fraction
  // bits; y and both states saturate, and any saturation sets clipped.
  bqf_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .sample_in        (sample_in),
    .end_of_block     (end_of_block),
    .sample_out       (sample_out),
    .end_of_block_out (end_of_block_out),
    .clipped          (clipped)
  );

endmodule

FILE: rtl/bqf_datapath.sv
`timescale 1ns / 1ps
module bqf_datapath #(
  parameter int SAMPLE_WIDTH = bqf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = bqf_pkg::COEF_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bqf_pkg::bqf_cmd_t                    cmd,
  input  logic                                 cfg_write_en,
  input  logic [bqf_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic signed [COEF_WIDTH-1:0]         cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
  input  logic                                 end_of_block,
  output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
  output logic                                 end_of_block_out,
  output logic                                 clipped
);

  localparam int STATE_W   = SAMPLE_WIDTH + 16;
  localparam int ACC_W     = STATE_W + 2;
  localparam int PROD_W    = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int COEF_FRAC = COEF_WIDTH - 3;

  localparam logic signed [COEF_WIDTH-1:0] COEF_UNITY = {3'b001, {COEF_FRAC{1'b0}}};
  localparam logic signed [ACC_W-1:0] Y_MAX = (ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] S_MAX = (ACC_W'(1) <<< (STATE_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] S_MIN = -S_MAX - ACC_W'(1);

  logic signed [COEF_WIDTH-1:0]   coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [STATE_W-1:0]      delay_one, delay_two;
  logic signed [SAMPLE_WIDTH-1:0] x_reg, y_reg;
  logic                           eob_reg, clip_reg;
  logic signed [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0]        acc_one, acc_two;

  logic signed [COEF_WIDTH-1:0]   mul_coef;
  logic signed [SAMPLE_WIDTH-1:0] mul_data;
  logic signed [PROD_W-1:0]       prod_next;
  logic signed [ACC_W-1:0]        prod_scaled, y_sum, y_sat, s1_sat, s2_sum, s2_sat;
  logic                           y_clip, s1_clip, s2_clip;

  // Coefficient registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= COEF_UNITY;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        bqf_pkg::REG_FEED_ZERO: coef_b0 <= cfg_data;
        bqf_pkg::REG_FEED_ONE:  coef_b1 <= cfg_data;
        bqf_pkg::REG_FEED_TWO:  coef_b2 <= cfg_data;
        bqf_pkg::REG_BACK_ONE:  coef_a1 <= cfg_data;
        bqf_pkg::REG_BACK_TWO:  coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_coef = coef_b0;
    mul_data = sample_in;
    if (!cmd.accept) begin
      case (cmd.op)
        bqf_pkg::OP_OUTPUT: begin
          mul_coef = coef_b1;
          mul_data = x_reg;
        end
        bqf_pkg::OP_S1_FF: begin
          mul_coef = coef_b2;
          mul_data = x_reg;
        end
        bqf_pkg::OP_S2_FF: begin
          mul_coef = coef_a1;
          mul_data = y_reg;
        end
        bqf_pkg::OP_S1_FB: begin
          mul_coef = coef_a2;
          mul_data = y_reg;
        end
        default: begin
          mul_coef = coef_b0;
          mul_data = x_reg;
        end
      endcase
    end
  end

  assign prod_next   = mul_coef * mul_data;
  assign prod_scaled = ACC_W'(prod >>> COEF_FRAC);

  // Output sample with saturation to the sample range.
  assign y_sum  = prod_scaled + ACC_W'(delay_one);
  assign y_clip = (y_sum > Y_MAX) || (y_sum < Y_MIN);
  assign y_sat  = (y_sum > Y_MAX) ? Y_MAX : ((y_sum < Y_MIN) ? Y_MIN : y_sum);

  // State saturation to the delay register range.
  assign s1_clip = (acc_one > S_MAX) || (acc_one < S_MIN);
  assign s1_sat  = (acc_one > S_MAX) ? S_MAX : ((acc_one < S_MIN) ? S_MIN : acc_one);
  assign s2_sum  = acc_two - prod_scaled;
  assign s2_clip = (s2_sum > S_MAX) || (s2_sum < S_MIN);
  assign s2_sat  = (s2_sum > S_MAX) ? S_MAX : ((s2_sum < S_MIN) ? S_MIN : s2_sum);

  always_ff @(posedge clk) begin
    if (cmd.accept || (cmd.op != bqf_pkg::OP_NONE && cmd.op != bqf_pkg::OP_COMMIT)) begin
      prod <= prod_next;
    end
    if (cmd.accept) begin
      x_reg   <= sample_in;
      eob_reg <= end_of_block;
    end
    case (cmd.op)
      bqf_pkg::OP_OUTPUT: begin
        y_reg    <= y_sat[SAMPLE_WIDTH-1:0];
        clip_reg <= y_clip;
      end
      bqf_pkg::OP_S1_FF: acc_one <= prod_scaled + ACC_W'(delay_two);
      bqf_pkg::OP_S2_FF: acc_two <= prod_scaled;
      bqf_pkg::OP_S1_FB: acc_one <= acc_one - prod_scaled;
      bqf_pkg::OP_COMMIT: begin
        sample_out       <= y_reg;
        end_of_block_out <= eob_reg;
        clipped          <= clip_reg | s1_clip | s2_clip;
      end
      default: ;
    endcase
  end

  // Delay states.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
    end else if (cmd.op == bqf_pkg::OP_COMMIT) begin
      delay_one <= s1_sat[STATE_W-1:0];
      delay_two <= s2_sat[STATE_W-1:0];
    end
  end

endmodule

FILE: rtl/bqf_controller.sv
`timescale 1ns / 1ps
module bqf_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output bqf_pkg::bqf_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_OUTPUT = 3'd1;
  localparam logic [2:0] ST_S1_FF  = 3'd2;
  localparam logic [2:0] ST_S2_FF  = 3'd3;
  localparam logic [2:0] ST_S1_FB  = 3'd4;
  localparam logic [2:0] ST_COMMIT = 3'd5;

  logic [2:0] state, state_next;
  logic       accept, out_free, commit;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // The output register can be reloaded once it is empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == ST_COMMIT) && out_free;

  always_comb begin
    state_next = state;
    cmd.accept = accept;
    cmd.op     = bqf_pkg::OP_NONE;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        cmd.op     = bqf_pkg::OP_OUTPUT;
        state_next = ST_S1_FF;
      end
      ST_S1_FF: begin
        cmd.op     = bqf_pkg::OP_S1_FF;
        state_next = ST_S2_FF;
      end
      ST_S2_FF: begin
        cmd.op     = bqf_pkg::OP_S2_FF;
        state_next = ST_S1_FB;
      end
      ST_S1_FB: begin
        cmd.op     = bqf_pkg::OP_S1_FB;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.op     = bqf_pkg::OP_COMMIT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_OUTPUT))
    else $error("accepted sample did not start the sequence");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    commit |=> (out_valid && state == ST_IDLE))
    else $error("committed result not presented");

  a_commit_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT && out_valid && out_stall) |=> (state == ST_COMMIT))
    else $error("result overwrote a stalled output");

  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !commit) |=> !out_valid)
    else $error("taken result presented twice");

endmodule
